/* rtl/icr_pkg.sv */
// ----------------------------------------------------------------------------
// icr_pkg: shared types and constants for the integer cube root
// Seed table, field widths and the sideband that rides the pipeline.
// ----------------------------------------------------------------------------
package icr_pkg;

  localparam int VALUE_W  = 64;
  localparam int ROOT_W   = 22;
  localparam int LEN_W    = 7;
  localparam int EXP_W    = 5;
  localparam int SH_W     = 7;
  localparam int SEED_W   = 8;
  localparam int IDX_W    = 6;
  localparam int SROOT_W  = 3;
  localparam int X_W      = 23;
  localparam int XS_W     = 29;
  localparam int DIV_W    = 46;
  localparam int Q_W      = 32;
  localparam int STEPS    = VALUE_W;

  localparam logic [LEN_W-1:0]  SMALL_LEN   = 7'd7;
  localparam logic [13:0]       EXP_MUL     = 14'd84;
  localparam logic [8:0]        ROUND_SMALL = 9'd35;
  localparam logic [8:0]        ROUND_EST   = 9'd10;
  localparam logic [Q_W-1:0]    THIRD_MUL   = 32'd341;

  localparam logic [SEED_W-1:0] SEED_TABLE [64] = '{
    8'd0,   8'd54,  8'd54,  8'd54,  8'd118, 8'd118, 8'd118, 8'd118,
    8'd123, 8'd129, 8'd134, 8'd138, 8'd143, 8'd147, 8'd151, 8'd156,
    8'd157, 8'd161, 8'd164, 8'd168, 8'd170, 8'd173, 8'd176, 8'd179,
    8'd181, 8'd185, 8'd187, 8'd190, 8'd192, 8'd194, 8'd197, 8'd199,
    8'd200, 8'd202, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd215,
    8'd217, 8'd219, 8'd221, 8'd222, 8'd224, 8'd225, 8'd227, 8'd229,
    8'd231, 8'd232, 8'd234, 8'd236, 8'd237, 8'd239, 8'd240, 8'd242,
    8'd244, 8'd245, 8'd246, 8'd248, 8'd250, 8'd251, 8'd252, 8'd254
  };

  // per-item data carried alongside the divider
  typedef struct packed {
    logic               is_small;
    logic [SROOT_W-1:0] sroot;
    logic               dz;
    logic [X_W-1:0]     x;
  } icr_side_t;

  function automatic logic [LEN_W-1:0] icr_bit_len(input logic [VALUE_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < VALUE_W; i++) begin
      if (v[i]) begin
        n = LEN_W'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic logic [SEED_W-1:0] icr_seed(input logic [IDX_W-1:0] idx);
    return SEED_TABLE[idx];
  endfunction

endpackage

/* rtl/icr_if.sv */
// ----------------------------------------------------------------------------
// icr_if: request channels of the integer cube root
// Operand channel and root channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface icr_value_if;
  logic                        valid;
  logic                        ready;
  logic [icr_pkg::VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface icr_root_if;
  logic                       valid;
  logic                       ready;
  logic [icr_pkg::ROOT_W-1:0] root;
  modport source (output valid, output root, input ready);
  modport sink (input valid, input root, output ready);
endinterface

/* rtl/icr_div.sv */
// ----------------------------------------------------------------------------
// icr_div: pipelined restoring divider
// One quotient bit per stage, 64 stages; sideband travels with each request.
// ----------------------------------------------------------------------------
module icr_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  icr_pkg::icr_side_t          in_side,
  input  logic [icr_pkg::VALUE_W-1:0] dividend,
  input  logic [icr_pkg::DIV_W-1:0]   divisor,
  output logic                        out_valid,
  output icr_pkg::icr_side_t          out_side,
  output logic [icr_pkg::Q_W-1:0]     quotient
);
  import icr_pkg::*;

  logic               vld  [STEPS];
  icr_side_t          side [STEPS];
  logic [DIV_W-1:0]   rem  [STEPS];
  logic [VALUE_W-1:0] dq   [STEPS];
  logic [DIV_W-1:0]   dvr  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic               p_vld;
    icr_side_t          p_side;
    logic [DIV_W-1:0]   p_rem;
    logic [VALUE_W-1:0] p_dq;
    logic [DIV_W-1:0]   p_dvr;
    logic [DIV_W:0]     trial;
    logic [DIV_W+1:0]   diff;
    logic               ge;

    if (k == 0) begin : g_first
      assign p_vld  = in_valid;
      assign p_side = in_side;
      assign p_rem  = '0;
      assign p_dq   = dividend;
      assign p_dvr  = divisor;
    end else begin : g_next
      assign p_vld  = vld[k-1];
      assign p_side = side[k-1];
      assign p_rem  = rem[k-1];
      assign p_dq   = dq[k-1];
      assign p_dvr  = dvr[k-1];
    end

    assign trial = {p_rem, p_dq[VALUE_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, p_dvr};
    assign ge    = ~diff[DIV_W+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= p_side;
        rem[k]  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        dq[k]   <= {p_dq[VALUE_W-2:0], ge};
        dvr[k]  <= p_dvr;
      end
    end
  end

  assign out_valid = vld[STEPS-1];
  assign out_side  = side[STEPS-1];
  assign quotient  = dq[STEPS-1][Q_W-1:0];

endmodule

/* rtl/integer_cube_root.sv */
// ----------------------------------------------------------------------------
// integer_cube_root: approximate cube root of a 64-bit operand
// Table seed, one Newton step through a pipelined divider, divide by three.
// Throughput: one operand per cycle unless a full output queue stalls the flow;
// the 64-stage divider sets the depth.
// Two-entry output queue lets the pipeline keep taking operands while a root waits.
// Reset clears all valid bits and empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
module integer_cube_root (
  input logic        clk,
  input logic        rst,
  icr_value_if.sink  operand,
  icr_root_if.source result
);
  import icr_pkg::*;

  logic en;

  // stage 0: operand register
  logic               st0_valid;
  logic [VALUE_W-1:0] st0_value;

  // stage 1: bit length
  logic               st1_valid;
  logic [VALUE_W-1:0] st1_value;
  logic [LEN_W-1:0]   st1_len;

  // stage 2: exponent and seed
  logic               st2_valid;
  logic [VALUE_W-1:0] st2_value;
  logic               st2_small;
  logic [EXP_W-1:0]   st2_b;
  logic [SEED_W-1:0]  st2_seed;

  // stage 3: estimate
  logic               st3_valid;
  logic [VALUE_W-1:0] st3_value;
  logic               st3_small;
  logic [SROOT_W-1:0] st3_sroot;
  logic [X_W-1:0]     st3_x;

  // stage 4: divisor
  logic               st4_valid;
  logic [VALUE_W-1:0] st4_value;
  logic [DIV_W-1:0]   st4_dv;
  icr_side_t          st4_side;

  // divider output
  logic               dq_valid;
  icr_side_t          dq_side;
  logic [Q_W-1:0]     dq_q;

  // Newton sum
  logic               t_valid;
  logic [Q_W-1:0]     t_sum;
  logic               t_small;
  logic [SROOT_W-1:0] t_sroot;

  // output queue
  logic [ROOT_W-1:0]  oq [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         cnt;
  logic               push;
  logic               pop;

  // combinational stage logic
  logic [LEN_W-1:0]   len1;
  logic               small1;
  logic [13:0]        lprod1;
  logic [EXP_W-1:0]   b1;
  logic [SH_W-1:0]    sh1;
  logic [VALUE_W-1:0] shifted1;
  logic [IDX_W-1:0]   idx1;
  logic [XS_W-1:0]    xs2;
  logic [8:0]         sr2;
  logic [X_W-1:0]     xm1_3;
  logic [Q_W-1:0]     q_eff;
  logic [Q_W-1:0]     prod_t;
  logic [ROOT_W-1:0]  root_f;

  assign en            = (cnt != 2'd2) || !t_valid;
  assign operand.ready = en;

  always_comb begin
    len1     = icr_bit_len(st0_value);
    small1   = st1_len < SMALL_LEN;
    lprod1   = 14'(st1_len) * EXP_MUL;
    b1       = lprod1[12:8] - 5'd1;
    sh1      = {1'b0, b1, 1'b0} + {2'b00, b1};
    shifted1 = st1_value >> sh1;
    idx1     = small1 ? st1_value[IDX_W-1:0] : shifted1[IDX_W-1:0];
    xs2      = XS_W'({1'b0, st2_seed} + ROUND_EST) << st2_b;
    sr2      = {1'b0, st2_seed} + ROUND_SMALL;
    xm1_3    = st3_x - 23'd1;
    q_eff    = dq_side.dz ? '0 : dq_q;
    prod_t   = t_sum * THIRD_MUL;
    root_f   = t_small ? ROOT_W'(t_sroot) : prod_t[Q_W-1:10];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st0_valid <= 1'b0;
      st1_valid <= 1'b0;
      st2_valid <= 1'b0;
      st3_valid <= 1'b0;
      st4_valid <= 1'b0;
      t_valid   <= 1'b0;
    end else if (en) begin
      st0_valid <= operand.valid;
      st1_valid <= st0_valid;
      st2_valid <= st1_valid;
      st3_valid <= st2_valid;
      st4_valid <= st3_valid;
      t_valid   <= dq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st0_value <= operand.value;

      st1_value <= st0_value;
      st1_len   <= len1;

      st2_value <= st1_value;
      st2_small <= small1;
      st2_b     <= b1;
      st2_seed  <= icr_seed(idx1);

      st3_value <= st2_value;
      st3_small <= st2_small;
      st3_sroot <= sr2[8:6];
      st3_x     <= xs2[XS_W-1:6];

      st4_value         <= st3_value;
      st4_dv            <= DIV_W'(st3_x) * DIV_W'(xm1_3);
      st4_side.is_small <= st3_small;
      st4_side.sroot    <= st3_sroot;
      st4_side.dz       <= (st3_x[X_W-1:1] == '0);
      st4_side.x        <= st3_x;

      t_sum   <= Q_W'({dq_side.x, 1'b0}) + q_eff;
      t_small <= dq_side.is_small;
      t_sroot <= dq_side.sroot;
    end
  end

  icr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (st4_valid),
    .in_side   (st4_side),
    .dividend  (st4_value),
    .divisor   (st4_dv),
    .out_valid (dq_valid),
    .out_side  (dq_side),
    .quotient  (dq_q)
  );

  // output queue
  assign push         = en && t_valid;
  assign pop          = result.valid && result.ready;
  assign result.valid = (cnt != 2'd0);
  assign result.root  = oq[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      oq[wr_ptr] <= root_f;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> cnt != 2'd2)
    else $error("push into full output queue");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> t_valid)
    else $error("pipeline lost a request during stall");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    st4_valid && !st4_side.is_small |-> !st4_side.dz)
    else $error("zero divisor on Newton path");

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(push) |-> result.valid)
    else $error("pushed root not presented");

endmodule
